[hw/rtl/bdclp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdclp_pkg
// Shared types and constants of the button debouncer with click and
// long-press detection.
// ----------------------------------------------------------------------------
package bdclp_pkg;

    localparam int unsigned NUM_BUTTONS_DEF  = 7;
    localparam int unsigned DEBOUNCE_W       = 10;
    localparam int unsigned LONG_W           = 16;
    localparam int unsigned TIME_W           = 32;
    localparam int unsigned APB_ADDR_W       = 3;
    localparam int unsigned APB_DATA_W       = 32;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(10);
    localparam logic [LONG_W-1:0]     LONG_RESET     = LONG_W'(500);

    // register index, taken from paddr[2]
    typedef enum logic
    {
        REG_DEBOUNCE = 1'b0,
        REG_LONG     = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic [DEBOUNCE_W-1:0] debounce_ms;
        logic [LONG_W-1:0]     long_press_ms;
    } cfg_t;

    // what one lane found for one transaction
    typedef struct packed
    {
        logic rise;
        logic fall;
        logic click;
        logic lstart;
        logic lend;
    } lane_flags_t;

endpackage

[hw/rtl/bdclp_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdclp_lane
// Debouncer and press-length tracker for a single button.
// ----------------------------------------------------------------------------
module bdclp_lane
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  bdclp_pkg::cfg_t               cfg,
    input  logic [bdclp_pkg::TIME_W-1:0]  now_ms,
    input  logic                          level,
    output bdclp_pkg::lane_flags_t        flags
);
    import bdclp_pkg::*;

    logic              pressed_reg;
    logic              pressed_next;
    logic              long_rep_reg;
    logic              long_rep_next;
    logic [TIME_W-1:0] last_change_reg;
    logic [TIME_W-1:0] last_change_next;
    logic [TIME_W-1:0] press_start_reg;
    logic [TIME_W-1:0] press_start_next;

    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] held;
    logic              settled;
    logic              held_long;

    // differences wrap modulo 2^32
    assign since_change = now_ms - last_change_reg;
    assign held         = now_ms - press_start_reg;
    assign settled      = since_change >= TIME_W'(cfg.debounce_ms);
    assign held_long    = held >= TIME_W'(cfg.long_press_ms);

    always_comb
    begin
        pressed_next     = pressed_reg;
        long_rep_next    = long_rep_reg;
        last_change_next = last_change_reg;
        press_start_next = press_start_reg;
        flags            = '0;
        if (!pressed_reg)
        begin
            if (level)
            begin
                if (settled)
                begin
                    flags.rise       = 1'b1;
                    pressed_next     = 1'b1;
                    press_start_next = now_ms;
                    last_change_next = now_ms;
                end
            end
            else
            begin
                last_change_next = now_ms;
            end
        end
        else
        begin
            if (!level)
            begin
                if (settled)
                begin
                    flags.fall       = 1'b1;
                    pressed_next     = 1'b0;
                    long_rep_next    = 1'b0;
                    last_change_next = now_ms;
                    flags.lend       = held_long;
                    flags.click      = !held_long;
                end
            end
            else
            begin
                if (held_long && !long_rep_reg)
                begin
                    flags.lstart  = 1'b1;
                    long_rep_next = 1'b1;
                end
                last_change_next = now_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg     <= 1'b0;
            long_rep_reg    <= 1'b0;
            last_change_reg <= '0;
            press_start_reg <= '0;
        end
        else if (accept)
        begin
            pressed_reg     <= pressed_next;
            long_rep_reg    <= long_rep_next;
            last_change_reg <= last_change_next;
            press_start_reg <= press_start_next;
        end
    end

endmodule

[hw/rtl/bdclp_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdclp_merge
// Packs the lane flags into result masks and holds them in an output
// register backed by a skid stage.
// ----------------------------------------------------------------------------
module bdclp_merge
#(
    parameter int unsigned NUM_BUTTONS = bdclp_pkg::NUM_BUTTONS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  bdclp_pkg::lane_flags_t        lane_flags [NUM_BUTTONS],
    output logic                          in_stall,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [NUM_BUTTONS-1:0]        rising_mask,
    output logic [NUM_BUTTONS-1:0]        falling_mask,
    output logic [NUM_BUTTONS-1:0]        click_mask,
    output logic [NUM_BUTTONS-1:0]        long_start_mask,
    output logic [NUM_BUTTONS-1:0]        long_end_mask
);
    import bdclp_pkg::*;

    typedef struct packed
    {
        logic [NUM_BUTTONS-1:0] rise;
        logic [NUM_BUTTONS-1:0] fall;
        logic [NUM_BUTTONS-1:0] click;
        logic [NUM_BUTTONS-1:0] lstart;
        logic [NUM_BUTTONS-1:0] lend;
    } mask_set_t;

    mask_set_t new_masks;
    mask_set_t out_reg;
    mask_set_t out_next;
    mask_set_t skid_reg;
    mask_set_t skid_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    logic      out_free;

    always_comb
    begin
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            new_masks.rise[b]   = lane_flags[b].rise;
            new_masks.fall[b]   = lane_flags[b].fall;
            new_masks.click[b]  = lane_flags[b].click;
            new_masks.lstart[b] = lane_flags[b].lstart;
            new_masks.lend[b]   = lane_flags[b].lend;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = new_masks;
                out_valid_next = accept;
            end
        end
        else if (accept)
        begin
            // output held, park the transaction in the skid stage
            skid_next       = new_masks;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign in_stall        = skid_valid_reg;
    assign out_valid       = out_valid_reg;
    assign rising_mask     = out_reg.rise;
    assign falling_mask    = out_reg.fall;
    assign click_mask      = out_reg.click;
    assign long_start_mask = out_reg.lstart;
    assign long_end_mask   = out_reg.lend;

endmodule

[hw/rtl/button_debounce_click_long_press.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_click_long_press
// Per-button debouncer with rising/falling edge, click and long-press events.
// ----------------------------------------------------------------------------
// One sample (timestamp plus one raw level per button) is taken every clock
// cycle while in_stall is low; its result is registered. Each button has its
// own lane, which compares the wrapped time since its last matching sample
// against debounce_ms and the hold time against long_press_ms and updates its
// state in the cycle the sample is accepted; that one subtract-and-compare per
// lane sets the rate. An output register with a skid stage behind it keeps
// samples flowing while a result waits. There is no clearing pass after reset.
// Registers: debounce_ms at byte address 0, long_press_ms at byte address 4.
module button_debounce_click_long_press
#(
    parameter int unsigned NUM_BUTTONS = bdclp_pkg::NUM_BUTTONS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bdclp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bdclp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bdclp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bdclp_pkg::TIME_W-1:0]      now_ms,
    input  logic [NUM_BUTTONS-1:0]            levels,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [NUM_BUTTONS-1:0]            rising_mask,
    output logic [NUM_BUTTONS-1:0]            falling_mask,
    output logic [NUM_BUTTONS-1:0]            click_mask,
    output logic [NUM_BUTTONS-1:0]            long_start_mask,
    output logic [NUM_BUTTONS-1:0]            long_end_mask
);
    import bdclp_pkg::*;

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    reg_idx_t    reg_idx;
    logic        wr_en;
    logic        accept;
    lane_flags_t lane_flags [NUM_BUTTONS];

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (reg_idx)
            REG_DEBOUNCE:
            begin
                prdata = APB_DATA_W'(cfg_reg.debounce_ms);
                if (wr_en)
                begin
                    cfg_next.debounce_ms = pwdata[DEBOUNCE_W-1:0];
                end
            end
            REG_LONG:
            begin
                prdata = APB_DATA_W'(cfg_reg.long_press_ms);
                if (wr_en)
                begin
                    cfg_next.long_press_ms = pwdata[LONG_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms   <= DEBOUNCE_RESET;
            cfg_reg.long_press_ms <= LONG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign accept = in_valid && !in_stall;

    for (genvar b = 0; b < NUM_BUTTONS; b++)
    begin : g_lane
        bdclp_lane u_lane
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .accept (accept),
            .cfg    (cfg_reg),
            .now_ms (now_ms),
            .level  (levels[b]),
            .flags  (lane_flags[b])
        );
    end

    bdclp_merge #(.NUM_BUTTONS(NUM_BUTTONS)) u_merge
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .lane_flags      (lane_flags),
        .in_stall        (in_stall),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .rising_mask     (rising_mask),
        .falling_mask    (falling_mask),
        .click_mask      (click_mask),
        .long_start_mask (long_start_mask),
        .long_end_mask   (long_end_mask)
    );

endmodule

[hw/rtl/bdclp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdclp_checker
// Port-level checks on the result transactions of the debouncer.
// ----------------------------------------------------------------------------
module bdclp_checker
#(
    parameter int unsigned NUM_BUTTONS = bdclp_pkg::NUM_BUTTONS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [NUM_BUTTONS-1:0] rising_mask,
    input  logic [NUM_BUTTONS-1:0] falling_mask,
    input  logic [NUM_BUTTONS-1:0] click_mask,
    input  logic [NUM_BUTTONS-1:0] long_start_mask,
    input  logic [NUM_BUTTONS-1:0] long_end_mask
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(rising_mask) && $stable(falling_mask)
                                   && $stable(click_mask) && $stable(long_start_mask)
                                   && $stable(long_end_mask))
        else $error("stalled result changed");

    // a button cannot both press and release in one sample
    a_edge_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rising_mask & falling_mask) == '0)
        else $error("rising and falling on the same button");

    // every release is exactly one of click or long end
    a_release_split: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((click_mask | long_end_mask) == falling_mask)
                      && ((click_mask & long_end_mask) == '0))
        else $error("release not split into click or long end");

    // long start only fires on a button already held
    a_lstart_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (long_start_mask & (rising_mask | falling_mask)) == '0)
        else $error("long start on a changing button");

endmodule

bind button_debounce_click_long_press bdclp_checker #(.NUM_BUTTONS(NUM_BUTTONS)) u_bdclp_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .rising_mask     (rising_mask),
    .falling_mask    (falling_mask),
    .click_mask      (click_mask),
    .long_start_mask (long_start_mask),
    .long_end_mask   (long_end_mask)
);
